// ===== hdl/hsv2rgb_pkg.sv =====
package hsv2rgb_pkg;

    localparam int HUE_W = 15;
    localparam int CH_W  = 8;
    localparam int SV_W  = 2 * CH_W;

    // Divisor left once the 1 << frac factor of 255 * 60 << frac is taken out.
    localparam int DIV_K       = 255 * 60;
    localparam int Z_W         = 22;
    localparam int RECIP_SHIFT = 22;
    localparam int RECIP       = (1 << RECIP_SHIFT) / DIV_K;
    localparam int RECIP_W     = $clog2(RECIP + 1);

    typedef enum logic [2:0] {
        SEXT_0    = 3'd0,
        SEXT_1    = 3'd1,
        SEXT_2    = 3'd2,
        SEXT_3    = 3'd3,
        SEXT_4    = 3'd4,
        SEXT_5    = 3'd5,
        SEXT_GREY = 3'd6
    } t_sextant;

    typedef struct packed {
        logic [HUE_W-1:0] hue;
        logic [CH_W-1:0]  saturation;
        logic [CH_W-1:0]  brightness;
    } t_hsv_req;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } t_rgb_resp;

    typedef struct packed {
        t_sextant        sextant;
        logic [CH_W-1:0] val;
        logic [CH_W-1:0] low;
    } t_side;

endpackage

// ===== hdl/hsv2rgb_front.sv =====
module hsv2rgb_front #(
    parameter int HUE_FRAC_BITS = 6,
    localparam int PERIOD = 60 << HUE_FRAC_BITS,
    localparam int W_W    = $clog2(PERIOD + 1)
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  hsv2rgb_pkg::t_hsv_req       i_req,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [hsv2rgb_pkg::SV_W-1:0] o_sv,
    output logic [W_W-1:0]              o_weight,
    output hsv2rgb_pkg::t_side          o_side
);
    import hsv2rgb_pkg::*;

    localparam int T_W_RAW = $clog2(6 * PERIOD + 1);
    localparam int T_W     = (T_W_RAW > HUE_W) ? T_W_RAW : HUE_W;

    logic             r_v1;
    logic             r_v2;
    logic             adv1;
    logic             adv2;

    logic [T_W-1:0]   hue_ext;
    t_sextant         n_sext;

    logic [HUE_W-1:0] r_hue1;
    t_sextant         r_sext1;
    logic [SV_W-1:0]  r_sv1;
    logic [CH_W-1:0]  r_val1;

    logic [T_W-1:0]   base;
    logic [T_W-1:0]   rem_full;
    logic [W_W-1:0]   rem;
    logic             odd;
    logic [W_W-1:0]   n_weight;
    logic [16:0]      grey_t;
    logic [16:0]      grey_s;
    logic [CH_W-1:0]  n_low;

    logic [SV_W-1:0]  r_sv2;
    logic [W_W-1:0]   r_weight2;
    t_side            r_side2;

    assign adv2    = !r_v2 || !i_stall;
    assign adv1    = !r_v1 || adv2;
    assign o_stall = !adv1;

    always_comb begin
        hue_ext = T_W'(i_req.hue);
        if (hue_ext < T_W'(PERIOD)) begin
            n_sext = SEXT_0;
        end else if (hue_ext < T_W'(2 * PERIOD)) begin
            n_sext = SEXT_1;
        end else if (hue_ext < T_W'(3 * PERIOD)) begin
            n_sext = SEXT_2;
        end else if (hue_ext < T_W'(4 * PERIOD)) begin
            n_sext = SEXT_3;
        end else if (hue_ext < T_W'(5 * PERIOD)) begin
            n_sext = SEXT_4;
        end else if (hue_ext < T_W'(6 * PERIOD)) begin
            n_sext = SEXT_5;
        end else begin
            n_sext = SEXT_GREY;
        end
    end

    always_comb begin
        case (r_sext1)
            SEXT_0:  base = '0;
            SEXT_1:  base = T_W'(PERIOD);
            SEXT_2:  base = T_W'(2 * PERIOD);
            SEXT_3:  base = T_W'(3 * PERIOD);
            SEXT_4:  base = T_W'(4 * PERIOD);
            SEXT_5:  base = T_W'(5 * PERIOD);
            default: base = '0;
        endcase
        rem_full = T_W'(r_hue1) - base;
        rem      = rem_full[W_W-1:0];
        odd      = (r_sext1 == SEXT_1) || (r_sext1 == SEXT_3) || (r_sext1 == SEXT_5);
        n_weight = odd ? rem : (W_W'(PERIOD) - rem);

        // Ceiling of sv / 255, using the exact 16-bit divide-by-255 identity.
        grey_t = 17'(r_sv1) + 17'd254;
        grey_s = grey_t + 17'(grey_t[16:8]) + 17'd1;
        n_low  = r_val1 - grey_s[15:8];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (adv1) begin
                r_v1 <= i_valid;
            end
            if (adv2) begin
                r_v2 <= r_v1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv1) begin
            r_hue1  <= i_req.hue;
            r_sext1 <= n_sext;
            r_sv1   <= SV_W'(i_req.saturation) * SV_W'(i_req.brightness);
            r_val1  <= i_req.brightness;
        end
        if (adv2) begin
            r_sv2           <= r_sv1;
            r_weight2       <= n_weight;
            r_side2.sextant <= r_sext1;
            r_side2.val     <= r_val1;
            r_side2.low     <= n_low;
        end
    end

    assign o_valid  = r_v2;
    assign o_sv     = r_sv2;
    assign o_weight = r_weight2;
    assign o_side   = r_side2;

endmodule

// ===== hdl/hsv2rgb_scale.sv =====
module hsv2rgb_scale #(
    parameter int HUE_FRAC_BITS = 6,
    localparam int PERIOD = 60 << HUE_FRAC_BITS,
    localparam int W_W    = $clog2(PERIOD + 1)
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [hsv2rgb_pkg::SV_W-1:0] i_sv,
    input  logic [W_W-1:0]               i_weight,
    input  hsv2rgb_pkg::t_side           i_side,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [hsv2rgb_pkg::CH_W-1:0] o_quot,
    output logic                         o_round,
    output hsv2rgb_pkg::t_side           o_side
);
    import hsv2rgb_pkg::*;

    localparam int X_W = SV_W + W_W;
    localparam int P_W = Z_W + RECIP_W;

    logic [3:0]       r_v;
    logic [3:0]       adv;
    t_side            r_side [4];

    logic [X_W-1:0]   r_x;
    logic [X_W:0]     x_sum;
    logic [Z_W-1:0]   y;
    logic [Z_W-1:0]   r_z4;
    logic [P_W-1:0]   prod;
    logic [CH_W-1:0]  r_q5;
    logic [Z_W-1:0]   r_z5;
    logic [Z_W-1:0]   back;
    logic [Z_W-1:0]   resid;
    logic [CH_W-1:0]  r_q6;
    logic             r_round6;

    assign adv[3]  = !r_v[3] || !i_stall;
    assign adv[2]  = !r_v[2] || adv[3];
    assign adv[1]  = !r_v[1] || adv[2];
    assign adv[0]  = !r_v[0] || adv[1];
    assign o_stall = !adv[0];

    always_comb begin
        x_sum = (X_W + 1)'(r_x) + (X_W + 1)'((1 << HUE_FRAC_BITS) - 1);
        y     = x_sum[HUE_FRAC_BITS +: Z_W];
        prod  = P_W'(r_z4) * P_W'(RECIP);
        back  = Z_W'(r_q5) * Z_W'(DIV_K);
        resid = r_z5 - back;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (adv[0]) begin
                r_v[0] <= i_valid;
            end
            if (adv[1]) begin
                r_v[1] <= r_v[0];
            end
            if (adv[2]) begin
                r_v[2] <= r_v[1];
            end
            if (adv[3]) begin
                r_v[3] <= r_v[2];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv[0]) begin
            r_x       <= X_W'(i_sv) * X_W'(i_weight);
            r_side[0] <= i_side;
        end
        if (adv[1]) begin
            r_z4      <= y + Z_W'(DIV_K - 1);
            r_side[1] <= r_side[0];
        end
        if (adv[2]) begin
            r_q5      <= prod[RECIP_SHIFT +: CH_W];
            r_z5      <= r_z4;
            r_side[2] <= r_side[1];
        end
        if (adv[3]) begin
            r_q6      <= r_q5;
            r_round6  <= (resid >= Z_W'(DIV_K));
            r_side[3] <= r_side[2];
        end
    end

    assign o_valid = r_v[3];
    assign o_quot  = r_q6;
    assign o_round = r_round6;
    assign o_side  = r_side[3];

endmodule

// ===== hdl/hsv_to_rgb_converter_core.sv =====
// Channel    Direction  Handshake           Payload
// request    in         i_valid / o_stall   i_req (hue, saturation, brightness)
// result     out        o_valid / i_stall   o_rgb (red, green, blue)
//
// One request is taken in every cycle while o_stall is low, and results leave in request order.
// The depth is set by the two multiplications and the reciprocal divide, each in its own stage.
// Reset clears every stage's valid bit, so the pipeline comes up empty.
// A stall holds only the stages that are full; empty stages ahead of it keep filling.
module hsv_to_rgb_converter_core #(
    parameter int HUE_FRAC_BITS = 6
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_stall,
    input  hsv2rgb_pkg::t_hsv_req  i_req,
    output logic                   o_valid,
    input  logic                   i_stall,
    output hsv2rgb_pkg::t_rgb_resp o_rgb
);
    import hsv2rgb_pkg::*;

    localparam int PERIOD = 60 << HUE_FRAC_BITS;
    localparam int W_W    = $clog2(PERIOD + 1);

    logic             f_valid;
    logic             f_stall;
    logic [SV_W-1:0]  f_sv;
    logic [W_W-1:0]   f_weight;
    t_side            f_side;

    logic             s_valid;
    logic             s_stall;
    logic [CH_W-1:0]  s_quot;
    logic             s_round;
    t_side            s_side;

    logic             adv;
    logic [CH_W-1:0]  mid;
    t_rgb_resp        n_rgb;
    logic             r_valid;
    t_rgb_resp        r_rgb;

    hsv2rgb_front #(
        .HUE_FRAC_BITS(HUE_FRAC_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_req   (i_req),
        .o_valid (f_valid),
        .i_stall (f_stall),
        .o_sv    (f_sv),
        .o_weight(f_weight),
        .o_side  (f_side)
    );

    hsv2rgb_scale #(
        .HUE_FRAC_BITS(HUE_FRAC_BITS)
    ) u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (f_valid),
        .o_stall (f_stall),
        .i_sv    (f_sv),
        .i_weight(f_weight),
        .i_side  (f_side),
        .o_valid (s_valid),
        .i_stall (s_stall),
        .o_quot  (s_quot),
        .o_round (s_round),
        .o_side  (s_side)
    );

    assign adv     = !r_valid || !i_stall;
    assign s_stall = !adv;

    always_comb begin
        mid   = s_side.val - s_quot - CH_W'(s_round);
        n_rgb = '{red: s_side.low, green: s_side.low, blue: s_side.low};
        case (s_side.sextant)
            SEXT_0: begin
                n_rgb.red   = s_side.val;
                n_rgb.green = mid;
            end
            SEXT_1: begin
                n_rgb.red   = mid;
                n_rgb.green = s_side.val;
            end
            SEXT_2: begin
                n_rgb.green = s_side.val;
                n_rgb.blue  = mid;
            end
            SEXT_3: begin
                n_rgb.green = mid;
                n_rgb.blue  = s_side.val;
            end
            SEXT_4: begin
                n_rgb.red   = mid;
                n_rgb.blue  = s_side.val;
            end
            SEXT_5: begin
                n_rgb.red   = s_side.val;
                n_rgb.blue  = mid;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (adv) begin
            r_valid <= s_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_rgb <= n_rgb;
        end
    end

    assign o_valid = r_valid;
    assign o_rgb   = r_rgb;

endmodule

// ===== tb/tb_hsv_to_rgb_converter_core.sv =====
`timescale 1ns / 100ps

module tb_hsv_to_rgb_converter_core;
    import hsv2rgb_pkg::*;

    localparam int HUE_FRAC_BITS = 6;
    localparam int SEXT_SPAN     = 60 << HUE_FRAC_BITS;
    localparam int HUE_IN_RANGE  = 6 * SEXT_SPAN - 1;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int TAIL_CYCLES   = 20;

    logic      i_clk;
    logic      i_rst_n = 1'b0;
    logic      i_valid = 1'b0;
    logic      o_stall;
    t_hsv_req  i_req   = '0;
    logic      o_valid;
    logic      i_stall = 1'b0;
    t_rgb_resp o_rgb;

    t_hsv_req  pending_req[$];
    t_rgb_resp expected_rgb[$];
    logic      req_taken   = 1'b0;
    int        send_idle_pct = 0;
    int        recv_idle_pct = 0;
    int        cycle_count   = 0;
    int        error_count   = 0;

    hsv_to_rgb_converter_core #(
        .HUE_FRAC_BITS(HUE_FRAC_BITS)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_stall(o_stall),
        .i_req  (i_req),
        .o_valid(o_valid),
        .i_stall(i_stall),
        .o_rgb  (o_rgb)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic t_rgb_resp hsv_to_rgb(t_hsv_req req);
        longint unsigned hue, sat, bri, sext, offs, bound, sv, low, mid, full;
        t_sextant        sext_code;
        t_rgb_resp       rgb;
        hue  = req.hue;
        sat  = req.saturation;
        bri  = req.brightness;
        sext = hue / SEXT_SPAN;
        offs = hue % SEXT_SPAN;
        sv   = sat * bri;
        bound = sext[0] ? SEXT_SPAN - offs : offs;
        low  = bri - (sv + 254) / 255;
        mid  = bri - (sv * (SEXT_SPAN - bound) + 255 * SEXT_SPAN - 1) / (255 * SEXT_SPAN);
        full = bri;
        sext_code = (sext < 6) ? t_sextant'(sext) : SEXT_GREY;
        rgb.red   = low[CH_W-1:0];
        rgb.green = low[CH_W-1:0];
        rgb.blue  = low[CH_W-1:0];
        case (sext_code)
            SEXT_0: begin
                rgb.red   = full[CH_W-1:0];
                rgb.green = mid[CH_W-1:0];
            end
            SEXT_1: begin
                rgb.red   = mid[CH_W-1:0];
                rgb.green = full[CH_W-1:0];
            end
            SEXT_2: begin
                rgb.green = full[CH_W-1:0];
                rgb.blue  = mid[CH_W-1:0];
            end
            SEXT_3: begin
                rgb.green = mid[CH_W-1:0];
                rgb.blue  = full[CH_W-1:0];
            end
            SEXT_4: begin
                rgb.red   = mid[CH_W-1:0];
                rgb.blue  = full[CH_W-1:0];
            end
            SEXT_5: begin
                rgb.red   = full[CH_W-1:0];
                rgb.blue  = mid[CH_W-1:0];
            end
            default: begin
            end
        endcase
        return rgb;
    endfunction

    function automatic logic [CH_W-1:0] random_fraction();
        int pick;
        pick = $urandom_range(99);
        if (pick < 10) begin
            return '0;
        end else if (pick < 20) begin
            return '1;
        end
        return CH_W'($urandom_range(255));
    endfunction

    function automatic t_hsv_req random_req();
        t_hsv_req req;
        int       pick;
        pick = $urandom_range(99);
        if (pick < 15) begin
            req.hue = HUE_W'($urandom_range(6, 1) * SEXT_SPAN + $urandom_range(2) - 1);
        end else if (pick < 25) begin
            req.hue = HUE_W'($urandom_range((1 << HUE_W) - 1));
        end else begin
            req.hue = HUE_W'($urandom_range(HUE_IN_RANGE));
        end
        req.saturation = random_fraction();
        req.brightness = random_fraction();
        return req;
    endfunction

    task automatic add_req(int hue, int sat, int bri);
        t_hsv_req req;
        req.hue        = HUE_W'(hue);
        req.saturation = CH_W'(sat);
        req.brightness = CH_W'(bri);
        pending_req.push_back(req);
    endtask

    task automatic wait_drained();
        while (pending_req.size() != 0 || i_valid || expected_rgb.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    always @(negedge i_clk) begin
        t_hsv_req nxt_req;
        logic     nxt_valid;
        nxt_req   = i_req;
        nxt_valid = i_valid;
        if (i_rst_n && (!i_valid || req_taken)) begin
            nxt_valid = 1'b0;
            if (pending_req.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                nxt_req   = pending_req.pop_front();
                nxt_valid = 1'b1;
            end
        end
        i_valid <= nxt_valid;
        i_req   <= nxt_req;
        i_stall <= i_rst_n && ($urandom_range(99) < recv_idle_pct);
    end

    always @(posedge i_clk) begin
        t_rgb_resp want;
        cycle_count <= cycle_count + 1;
        req_taken   <= i_rst_n && i_valid && !o_stall;
        if (i_rst_n && i_valid && !o_stall) begin
            expected_rgb.push_back(hsv_to_rgb(i_req));
        end
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_rgb.size() == 0) begin
                if (error_count < 10) begin
                    $display("Unexpected result r=%0d g=%0d b=%0d",
                             o_rgb.red, o_rgb.green, o_rgb.blue);
                end
                error_count <= error_count + 1;
            end else begin
                want = expected_rgb.pop_front();
                if (o_rgb.red !== want.red || o_rgb.green !== want.green ||
                    o_rgb.blue !== want.blue) begin
                    if (error_count < 10) begin
                        $display("Mismatch: expected r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
                                 want.red, want.green, want.blue,
                                 o_rgb.red, o_rgb.green, o_rgb.blue);
                    end
                    error_count <= error_count + 1;
                end
            end
        end
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        int k;
        send_idle_pct = 19;
        recv_idle_pct = 63;

        for (k = 0; k < 6; k++) begin
            add_req(k * SEXT_SPAN + 1000, 255, 255);
        end
        for (k = 1; k < 6; k++) begin
            add_req(k * SEXT_SPAN, 255, 200);
        end
        for (k = 1; k <= 6; k++) begin
            add_req(k * SEXT_SPAN - 1, 200, 255);
        end
        add_req(0, 255, 255);
        add_req(1, 1, 1);
        add_req(6 * SEXT_SPAN, 255, 255);
        add_req((1 << HUE_W) - 1, 128, 255);
        add_req(5000, 0, 255);
        add_req(12345, 255, 0);

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // The sender holds off here until the pipeline has emptied completely.
        wait_drained();

        for (k = 0; k < 420; k++) begin
            pending_req.push_back(random_req());
        end
        while (pending_req.size() != 0) begin
            @(negedge i_clk);
        end

        send_idle_pct = 63;
        recv_idle_pct = 19;
        for (k = 0; k < 420; k++) begin
            pending_req.push_back(random_req());
        end
        while (pending_req.size() != 0) begin
            @(negedge i_clk);
        end

        send_idle_pct = 0;
        recv_idle_pct = 0;
        for (k = 0; k < 410; k++) begin
            pending_req.push_back(random_req());
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (error_count == 0 && expected_rgb.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hdl/hsv2rgb_pkg.sv
hdl/hsv2rgb_front.sv
hdl/hsv2rgb_scale.sv
hdl/hsv_to_rgb_converter_core.sv
tb/tb_hsv_to_rgb_converter_core.sv
